### rtl/fqme_pkg.sv
// Package for the job queue with minimum extraction.
// Holds the beat types, command, status and policy codes, and the stored job type.
// No dependencies.
package fqme_pkg;

    // Command codes carried by an input beat.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    // Status codes carried by an output beat.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Dequeue policy codes; the unused code behaves as oldest first.
    localparam logic [1:0] POLICY_OLDEST   = 2'd0;
    localparam logic [1:0] POLICY_DURATION = 2'd1;
    localparam logic [1:0] POLICY_PRIORITY = 2'd2;

    // One stored job, 40 bits.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] dur;
        logic [7:0]  prio;
    } job_t;

    // Input beat.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] item_id;
        logic [15:0] duration;
        logic [7:0]  priority_req;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [15:0] out_duration;
        logic [7:0]  out_priority;
        logic [4:0]  entries_left;
        logic        now_empty;
    } out_beat_t;

endpackage

### rtl/fifo_queue_min_extract_core.sv
// Top level of the job queue with minimum extraction.
// Holds the entry memory, the scan and close-up sequencer and the output register.
// Depends on fqme_pkg.

// A command beat is taken only while the sequencer is idle, and one output beat follows
// every command. Enqueue, clear and the unused command go from the idle state straight
// to the finish state. A dequeue sweeps the stored entries through the single read port
// of the entry memory in the scan state to find the chosen one. It then sweeps the
// entries behind it in the shift state to close the gap. The finish state hands the
// result to the output register once that is free and returns to idle for the next
// command. The output register lets the next command enter while a finished result
// still waits to be taken.
// The entry memory needs no clearing after reset; only entries below the count are read.
module fifo_queue_min_extract_core
    import fqme_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        policy_reg;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [15:0]       best_key_reg, best_key_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    job_t              best_job_reg, best_job_next;
    out_beat_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_beat_reg, out_beat_next;

    job_t              mem [CAPACITY];
    job_t              rd_data_reg;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    job_t              mem_wdata;

    logic              in_fire;
    logic [15:0]       rd_key;

    // Sort key of a job under the given policy; oldest first uses a constant key.
    function automatic logic [15:0] key_of(job_t j, logic [1:0] pol);
        logic [15:0] k;
        k = '0;
        case (pol)
            POLICY_DURATION: k = j.dur;
            POLICY_PRIORITY: k = {8'd0, j.prio};
            default:         k = '0;
        endcase
        return k;
    endfunction

    // Builds one output beat from a status, a job and the count after the command.
    function automatic out_beat_t make_res(logic [1:0] st, job_t j, logic [CNT_W-1:0] cnt);
        out_beat_t r;
        r.status       = st;
        r.out_id       = j.id;
        r.out_duration = j.dur;
        r.out_priority = j.prio;
        r.entries_left = 5'(cnt);
        r.now_empty    = (cnt == '0);
        return r;
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;
    assign rd_key    = key_of(rd_data_reg, policy_reg);
    assign mem_raddr = ptr_reg[IDX_W-1:0];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_OLDEST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        best_key_next  = best_key_reg;
        best_idx_next  = best_idx_reg;
        best_job_next  = best_job_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_beat_next  = out_beat_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = '{id: in_beat.item_id, dur: in_beat.duration,
                           prio: in_beat.priority_req};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_FINISH;
                    unique case (in_beat.cmd)
                        CMD_ENQUEUE:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_next = make_res(STATUS_FULL, '0, count_reg);
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                res_next   = make_res(STATUS_OK, '0, count_next);
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = make_res(STATUS_EMPTY, '0, count_reg);
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                ptr_next   = '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            res_next   = make_res(STATUS_OK, '0, '0);
                        end
                        default:
                        begin
                            res_next = make_res(STATUS_OK, '0, count_reg);
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue the next read while entries remain.
                if (ptr_reg < count_reg)
                begin
                    ptr_next    = ptr_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = ptr_reg[IDX_W-1:0];
                end
                // Compare the entry that returned; the earliest wins a tie.
                if (rvalid_reg)
                begin
                    if (ridx_reg == '0 || rd_key < best_key_reg)
                    begin
                        best_key_next = rd_key;
                        best_idx_next = ridx_reg;
                        best_job_next = rd_data_reg;
                    end
                end
                else if (ptr_reg >= count_reg)
                begin
                    state_next  = ST_SHIFT;
                    ptr_next    = CNT_W'(best_idx_reg) + 1'b1;
                    rvalid_next = 1'b0;
                end
            end

            ST_SHIFT:
            begin
                // Move each entry behind the removed one down by one place.
                if (ptr_reg < count_reg)
                begin
                    ptr_next    = ptr_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = ptr_reg[IDX_W-1:0];
                end
                if (rvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ridx_reg - 1'b1;
                    mem_wdata = rd_data_reg;
                end
                else if (ptr_reg >= count_reg)
                begin
                    state_next  = ST_FINISH;
                    rvalid_next = 1'b0;
                    count_next  = count_reg - 1'b1;
                    res_next    = make_res(STATUS_OK, best_job_reg, count_next);
                end
            end

            ST_FINISH:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_beat_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rvalid_reg    <= 1'b0;
            ridx_reg      <= '0;
            best_key_reg  <= '0;
            best_idx_reg  <= '0;
            best_job_reg  <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_beat_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rvalid_reg    <= rvalid_next;
            ridx_reg      <= ridx_next;
            best_key_reg  <= best_key_next;
            best_idx_reg  <= best_idx_next;
            best_job_reg  <= best_job_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_beat_reg  <= out_beat_next;
        end
    end

`ifndef SYNTHESIS
    // The stored count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Close-up writes stay inside the stored entries.
    a_shift_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && mem_we) |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("close-up write outside stored entries");

    // Only one command is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("command accepted while another is in work");

    // A dequeue on an empty queue returns zero job fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_beat.status == STATUS_EMPTY) |->
            (out_beat.out_id == '0 && out_beat.out_duration == '0
             && out_beat.out_priority == '0))
        else $error("empty dequeue carries job data");

    // A dequeue that succeeds leaves one entry fewer.
    a_dequeue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && state_next == ST_FINISH) |=>
            (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue did not remove exactly one entry");
`endif

endmodule
